// ===== rtl/core/utf8d_pkg.sv =====
// utf8d_pkg: shared types and constants for the UTF-8 stream decoder.
// Used by the result channel interface, the decode step and the top level.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CNT_W  = 17;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ZERO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // character count saturates at COUNT_CAP, 10000 hex (65536)
  localparam logic [CNT_W-1:0] COUNT_CAP = 17'd65536;

  localparam logic [7:0] B_CONT_LO = 8'h80;
  localparam logic [7:0] B_CONT_HI = 8'hBF;
  localparam logic [7:0] B_LEAD2   = 8'hC0;
  localparam logic [7:0] B_C1      = 8'hC1;
  localparam logic [7:0] B_C2      = 8'hC2;
  localparam logic [7:0] B_LEAD3   = 8'hE0;
  localparam logic [7:0] B_SURR    = 8'hED;
  localparam logic [7:0] B_LEAD4   = 8'hF0;
  localparam logic [7:0] B_F4      = 8'hF4;
  localparam logic [7:0] B_A0      = 8'hA0;
  localparam logic [7:0] B_90      = 8'h90;
  localparam logic [7:0] B_B0      = 8'hB0;

  localparam logic [CP_W-1:0] CP_PLANE1  = 21'h10000;
  localparam logic [CP_W-1:0] CP_HI_SURR = 21'h0D800;
  localparam logic [CP_W-1:0] CP_LO_SURR = 21'h0DC00;

  typedef struct packed {
    logic [2:0]       pending;
    logic [7:0]       lead;
    logic [CP_W-1:0]  partial;
    logic [9:0]       high_half;
    logic             in_pair;
    logic [CNT_W-1:0] chars_seen;
    logic             halted;
  } dec_state_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [LEN_W-1:0]  seq_len;
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  char_count;
    logic              done_res;
  } dec_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/utf8d_if.sv =====
// utf8d_if: valid/ready channels for the byte input and the decode results.
// Depends on utf8d_pkg for the result payload widths.
`default_nettype none

interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf8d_out_if import utf8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic [LEN_W-1:0]  seq_len;
  logic [KIND_W-1:0] kind;
  logic [CNT_W-1:0]  char_count;
  logic              done_res;

  modport source (output valid, output code_point, output seq_len, output kind,
                  output char_count, output done_res, input ready);
  modport sink   (input valid, input code_point, input seq_len, input kind,
                  input char_count, input done_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/utf8d_step.sv =====
// utf8d_step: next-state and result logic for one text byte.
// Depends on utf8d_pkg; purely combinational, registered by the top level.
`default_nettype none

module utf8d_step import utf8d_pkg::*; (
  input  dec_state_t  st,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic        zero_ends_text,
  output dec_state_t  st_nxt,
  output logic        res_valid,
  output dec_result_t res
);

  logic              emit;
  logic [KIND_W-1:0] e_kind;
  logic [CP_W-1:0]   e_cp;
  logic [LEN_W-1:0]  e_len;
  logic [2:0]        total;
  logic [2:0]        pend_dec;
  logic [CP_W-1:0]   shifted;
  logic              second_bad;
  logic [CNT_W-1:0]  cnt;
  logic              done;

  assign total = st.in_pair          ? 3'd3 :
                 (st.lead >= B_LEAD4) ? 3'd4 :
                 (st.lead >= B_LEAD3) ? 3'd3 : 3'd2;
  assign pend_dec = st.pending - 3'd1;
  assign shifted  = {st.partial[CP_W-7:0], text_byte[5:0]};

  // range checks that apply only to the byte right after a lead
  always_comb begin
    second_bad = 1'b0;
    if (st.pending == total - 3'd1) begin
      if (st.lead == B_LEAD2 && text_byte != B_CONT_LO) second_bad = 1'b1;
      if (st.lead == B_LEAD3 && text_byte < B_A0)       second_bad = 1'b1;
      if (st.lead == B_LEAD4 && text_byte < B_90)       second_bad = 1'b1;
      if (st.lead == B_F4 && text_byte >= B_90)         second_bad = 1'b1;
      if (st.lead == B_SURR) begin
        if (st.in_pair ? (text_byte < B_B0) : (text_byte >= B_B0)) second_bad = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt    = st;
    emit      = 1'b0;
    e_kind    = KIND_CHAR;
    e_cp      = '0;
    e_len     = '0;
    res_valid = 1'b0;
    res       = '0;
    cnt       = st.chars_seen;
    done      = 1'b0;

    if (st.halted) begin
      // drop bytes until end of text
      if (end_of_text) st_nxt = '0;
    end else if (st.pending == 3'd0) begin
      if (text_byte < B_CONT_LO) begin
        emit = 1'b1;
        if (text_byte == 8'h00 && zero_ends_text) begin
          e_kind = KIND_ZERO;
        end else begin
          e_cp  = {13'd0, text_byte};
          e_len = 3'd1;
        end
      end else if (text_byte < B_LEAD2 || text_byte == B_C1 || text_byte > B_F4) begin
        emit   = 1'b1;
        e_kind = KIND_ERROR;
      end else begin
        st_nxt.lead = text_byte;
        if (text_byte < B_LEAD3) begin
          st_nxt.partial = {16'd0, text_byte[4:0]};
          st_nxt.pending = 3'd1;
        end else if (text_byte < B_LEAD4) begin
          st_nxt.partial = {17'd0, text_byte[3:0]};
          st_nxt.pending = 3'd2;
        end else begin
          st_nxt.partial = {18'd0, text_byte[2:0]};
          st_nxt.pending = 3'd3;
        end
        if (end_of_text) begin
          emit   = 1'b1;
          e_kind = KIND_ERROR;
        end
      end
    end else if (st.in_pair && st.pending == 3'd3) begin
      // lead of the low surrogate half
      if (text_byte != B_SURR || end_of_text) begin
        emit   = 1'b1;
        e_kind = KIND_ERROR;
      end else begin
        st_nxt.lead    = B_SURR;
        st_nxt.partial = 21'h0000D;
        st_nxt.pending = 3'd2;
      end
    end else if (text_byte < B_CONT_LO || text_byte > B_CONT_HI || second_bad) begin
      emit   = 1'b1;
      e_kind = KIND_ERROR;
    end else if (pend_dec != 3'd0) begin
      st_nxt.partial = shifted;
      st_nxt.pending = pend_dec;
      if (end_of_text) begin
        emit   = 1'b1;
        e_kind = KIND_ERROR;
      end
    end else if (st.in_pair) begin
      // low surrogate bits sit in the low ten bits of the accumulator
      emit  = 1'b1;
      e_cp  = CP_PLANE1 + {1'b0, st.high_half, shifted[9:0]};
      e_len = 3'd6;
    end else if (total == 3'd3 && shifted >= CP_HI_SURR && shifted < CP_LO_SURR) begin
      // high surrogate: hold its bits and wait for the low half
      st_nxt.high_half = shifted[9:0];
      st_nxt.in_pair   = 1'b1;
      st_nxt.pending   = 3'd3;
      st_nxt.lead      = '0;
      st_nxt.partial   = '0;
      if (end_of_text) begin
        emit   = 1'b1;
        e_kind = KIND_ERROR;
      end
    end else begin
      emit  = 1'b1;
      e_cp  = shifted;
      e_len = total;
    end

    if (emit) begin
      done = (e_kind != KIND_CHAR) || end_of_text;
      if (e_kind == KIND_CHAR && st.chars_seen < COUNT_CAP) cnt = st.chars_seen + 17'd1;
      res_valid      = 1'b1;
      res.code_point = e_cp;
      res.seq_len    = e_len;
      res.kind       = e_kind;
      res.char_count = cnt;
      res.done_res   = done;
      st_nxt.pending    = '0;
      st_nxt.lead       = '0;
      st_nxt.partial    = '0;
      st_nxt.high_half  = '0;
      st_nxt.in_pair    = 1'b0;
      st_nxt.chars_seen = cnt;
      if (done) begin
        if (end_of_text) st_nxt = '0;
        else st_nxt.halted = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder.sv =====
// utf8_stream_decoder: top level of the UTF-8 byte stream decoder.
// Depends on utf8d_pkg, utf8d_if and utf8d_step.
//
// Decodes one text byte per beat into code points (strict UTF-8 plus C0 80
// as U+0000 and surrogate pairs as one six-byte character). The decode
// state updates at the accepting edge and a result, when the byte completes
// a character, an error or a zero terminator, appears in the output
// register on the next cycle. A new byte is taken in every cycle while the
// output register is empty or being drained, so the sustained rate is one
// byte per clock; the only stall is the result register waiting on
// out_ch.ready. Write cfg_wdata only while the decoder is idle.
`default_nettype none

module utf8_stream_decoder import utf8d_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  utf8d_in_if.sink   in_ch,
  utf8d_out_if.source out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  dec_state_t  st_r;
  dec_state_t  st_nxt;
  dec_result_t res_nxt;
  dec_result_t res_r;
  logic        res_valid_nxt;
  logic        out_valid_r;
  logic        zero_ends_r;
  logic        accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  utf8d_step u_step (
    .st             (st_r),
    .text_byte      (in_ch.text_byte),
    .end_of_text    (in_ch.end_of_text),
    .zero_ends_text (zero_ends_r),
    .st_nxt         (st_nxt),
    .res_valid      (res_valid_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
      zero_ends_r <= 1'b0;
    end else begin
      if (cfg_we) zero_ends_r <= cfg_wdata;
      if (accept) begin
        st_r        <= st_nxt;
        out_valid_r <= res_valid_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload holds until a new result is loaded
  always_ff @(posedge clk) begin
    if (accept && res_valid_nxt) res_r <= res_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = res_r.code_point;
  assign out_ch.seq_len    = res_r.seq_len;
  assign out_ch.kind       = res_r.kind;
  assign out_ch.char_count = res_r.char_count;
  assign out_ch.done_res   = res_r.done_res;

`ifndef SYNTH
  a_nonchar_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind != KIND_CHAR |-> res_r.done_res && res_r.seq_len == '0
      && res_r.code_point == '0)
    else $error("non-character result must be final with empty payload");

  a_halt_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_valid_nxt && res_nxt.kind != KIND_CHAR && !in_ch.end_of_text
      |=> st_r.halted)
    else $error("decoder did not halt after error or terminator");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.end_of_text |=> st_r == '0)
    else $error("text state not cleared at end of text");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.chars_seen <= COUNT_CAP && st_r.pending <= 3'd3)
    else $error("decoder state out of range");

  a_no_result_while_halted: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halted |-> !res_valid_nxt)
    else $error("result produced while halted");
`endif

endmodule

`default_nettype wire
